FILE: sv/atfe_pkg.sv
// Shared types, character codes and the decimal digit split for the truecolor encoder.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package atfe_pkg;

   // Field widths.
   localparam int ColorW  = 8;
   localparam int RowLenW = 12;
   localparam int CsrAddrW = 2;
   localparam int CsrDataW = 32;
   localparam logic [RowLenW-1:0] RowLenReset = 12'd192;
   localparam logic [CsrAddrW-1:0] RegRowLength = 2'd0;

   // Characters of the output text.
   localparam logic [7:0] CharEsc   = 8'd27;
   localparam logic [7:0] CharNl    = 8'd10;
   localparam logic [7:0] CharSpace = 8'd32;
   localparam logic [7:0] CharBrack = 8'd91;
   localparam logic [7:0] CharSemi  = 8'd59;
   localparam logic [7:0] CharZero  = 8'd48;
   localparam logic [7:0] CharTwo   = 8'd50;
   localparam logic [7:0] CharFour  = 8'd52;
   localparam logic [7:0] CharEight = 8'd56;
   localparam logic [7:0] CharM     = 8'd109;

   // One input pixel.
   typedef struct packed {
      logic [ColorW-1:0] red;
      logic [ColorW-1:0] green;
      logic [ColorW-1:0] blue;
      logic              frame_end;
   } req_type;

   // One output character.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       run_last;
   } rsp_type;

   // Decimal form of one channel: start is the index of the leading digit.
   typedef struct packed {
      logic [3:0] hun;
      logic [3:0] ten;
      logic [3:0] one;
      logic [1:0] start;
   } digits_type;

   // Work for the back end: what one pixel has to print.
   typedef struct packed {
      logic       newline;
      logic       escape;
      logic       last;
      digits_type dig_red;
      digits_type dig_green;
      digits_type dig_blue;
   } desc_type;

   // Splits an 8-bit value into decimal digits with a few narrow compares.
   function automatic digits_type to_digits(input logic [7:0] value);
      digits_type d;
      logic [7:0] rem;
      logic [3:0] tens;
      logic [7:0] ones;
      d = '0;
      if (value >= 8'd200) begin
         d.hun = 4'd2;
         rem   = value - 8'd200;
      end else if (value >= 8'd100) begin
         d.hun = 4'd1;
         rem   = value - 8'd100;
      end else begin
         d.hun = 4'd0;
         rem   = value;
      end
      tens = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rem >= 8'(10 * k)) begin
            tens = 4'(k);
         end
      end
      ones  = rem - 8'(tens * 10);
      d.ten = tens;
      d.one = ones[3:0];
      if (d.hun != 4'd0) begin
         d.start = 2'd2;
      end else if (d.ten != 4'd0) begin
         d.start = 2'd1;
      end else begin
         d.start = 2'd0;
      end
      return d;
   endfunction

endpackage

FILE: sv/atfe_front.sv
// Front end: takes pixels, tracks the last color and the column, and builds a work descriptor.
// Depends on atfe_pkg.
`timescale 1ns / 1ps

module atfe_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  atfe_pkg::req_type             req_data,
   input  logic [atfe_pkg::RowLenW-1:0]  row_length,
   input  logic                          q_full,
   output logic                          q_push,
   output atfe_pkg::desc_type            q_desc
);

   logic [atfe_pkg::ColorW-1:0]  prev_red_ff, prev_red_in;
   logic [atfe_pkg::ColorW-1:0]  prev_green_ff, prev_green_in;
   logic [atfe_pkg::ColorW-1:0]  prev_blue_ff, prev_blue_in;
   logic                         known_ff, known_in;
   logic [atfe_pkg::RowLenW-1:0] column_ff, column_in;
   logic [atfe_pkg::RowLenW:0]   column_inc;
   logic                         accept;
   logic                         escape;

   assign accept = req_push && !q_full;
   assign q_push = accept;

   // A color escape is due on a new color or on the first pixel of a frame.
   assign escape = !known_ff || (req_data.red != prev_red_ff) ||
                   (req_data.green != prev_green_ff) || (req_data.blue != prev_blue_ff);
   assign column_inc = {1'b0, column_ff} + 13'd1;

   // Descriptor for the back end.
   always_comb begin
      q_desc           = '0;
      q_desc.newline   = (column_ff == '0);
      q_desc.escape    = escape;
      q_desc.last      = req_data.frame_end;
      q_desc.dig_red   = atfe_pkg::to_digits(req_data.red);
      q_desc.dig_green = atfe_pkg::to_digits(req_data.green);
      q_desc.dig_blue  = atfe_pkg::to_digits(req_data.blue);
   end

   // Color and column state after this pixel.
   always_comb begin
      prev_red_in   = prev_red_ff;
      prev_green_in = prev_green_ff;
      prev_blue_in  = prev_blue_ff;
      known_in      = known_ff;
      column_in     = column_ff;
      if (accept) begin
         if (escape) begin
            prev_red_in   = req_data.red;
            prev_green_in = req_data.green;
            prev_blue_in  = req_data.blue;
            known_in      = 1'b1;
         end
         if (column_inc >= {1'b0, row_length}) begin
            column_in = '0;
         end else begin
            column_in = column_inc[atfe_pkg::RowLenW-1:0];
         end
         if (req_data.frame_end) begin
            prev_red_in   = '0;
            prev_green_in = '0;
            prev_blue_in  = '0;
            known_in      = 1'b0;
            column_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_red_ff   <= '0;
         prev_green_ff <= '0;
         prev_blue_ff  <= '0;
         known_ff      <= 1'b0;
         column_ff     <= '0;
      end else begin
         prev_red_ff   <= prev_red_in;
         prev_green_ff <= prev_green_in;
         prev_blue_ff  <= prev_blue_in;
         known_ff      <= known_in;
         column_ff     <= column_in;
      end
   end

endmodule

FILE: sv/atfe_queue.sv
// Two-entry queue of work descriptors between the front end and the back end.
// Depends on atfe_pkg.
`timescale 1ns / 1ps

module atfe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  atfe_pkg::desc_type push_desc,
   output logic               full,
   input  logic               pop,
   output atfe_pkg::desc_type pop_desc,
   output logic               empty
);

   atfe_pkg::desc_type mem_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_desc = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

FILE: sv/atfe_back.sv
// Back end: walks one descriptor byte by byte into an output register.
// Depends on atfe_pkg.
`timescale 1ns / 1ps

module atfe_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  atfe_pkg::desc_type q_desc,
   output logic               q_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output atfe_pkg::rsp_type  rsp_data
);

   localparam logic [3:0] PH_NL   = 4'd0;
   localparam logic [3:0] PH_PFX  = 4'd1;
   localparam logic [3:0] PH_RED  = 4'd2;
   localparam logic [3:0] PH_SEP1 = 4'd3;
   localparam logic [3:0] PH_GRN  = 4'd4;
   localparam logic [3:0] PH_SEP2 = 4'd5;
   localparam logic [3:0] PH_BLU  = 4'd6;
   localparam logic [3:0] PH_M    = 4'd7;
   localparam logic [3:0] PH_SP1  = 4'd8;
   localparam logic [3:0] PH_SP2  = 4'd9;
   localparam logic [3:0] PH_TAIL = 4'd10;

   atfe_pkg::desc_type cur_ff, cur_in;
   logic               busy_ff, busy_in;
   logic [3:0]         phase_ff, phase_in;
   logic [2:0]         sub_ff, sub_in;
   logic               out_valid_ff, out_valid_in;
   atfe_pkg::rsp_type  out_data_ff, out_data_in;
   logic               out_free;
   logic               emit;
   logic [7:0]         char;
   logic               final_char;
   atfe_pkg::digits_type dig;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign emit      = busy_ff && out_free;
   assign q_pop     = !busy_ff && !q_empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Digits of the channel now being printed.
   always_comb begin
      case (phase_ff)
         PH_RED:  dig = cur_ff.dig_red;
         PH_GRN:  dig = cur_ff.dig_green;
         default: dig = cur_ff.dig_blue;
      endcase
   end

   // Character for the current phase and position.
   always_comb begin
      char       = atfe_pkg::CharSpace;
      final_char = 1'b0;
      case (phase_ff)
         PH_NL: char = atfe_pkg::CharNl;
         PH_PFX: begin
            case (sub_ff)
               3'd0:    char = atfe_pkg::CharEsc;
               3'd1:    char = atfe_pkg::CharBrack;
               3'd2:    char = atfe_pkg::CharFour;
               3'd3:    char = atfe_pkg::CharEight;
               3'd4:    char = atfe_pkg::CharSemi;
               3'd5:    char = atfe_pkg::CharTwo;
               default: char = atfe_pkg::CharSemi;
            endcase
         end
         PH_RED, PH_GRN, PH_BLU: begin
            case (sub_ff)
               3'd2:    char = atfe_pkg::CharZero + {4'd0, dig.hun};
               3'd1:    char = atfe_pkg::CharZero + {4'd0, dig.ten};
               default: char = atfe_pkg::CharZero + {4'd0, dig.one};
            endcase
         end
         PH_SEP1, PH_SEP2: char = atfe_pkg::CharSemi;
         PH_M:   char = atfe_pkg::CharM;
         PH_SP1: char = atfe_pkg::CharSpace;
         PH_SP2: begin
            char       = atfe_pkg::CharSpace;
            final_char = !cur_ff.last;
         end
         PH_TAIL: begin
            case (sub_ff)
               3'd0:    char = atfe_pkg::CharEsc;
               3'd1:    char = atfe_pkg::CharBrack;
               3'd2:    char = atfe_pkg::CharZero;
               3'd3:    char = atfe_pkg::CharM;
               default: begin
                  char       = atfe_pkg::CharNl;
                  final_char = 1'b1;
               end
            endcase
         end
         default: char = atfe_pkg::CharSpace;
      endcase
   end

   // Sequencer: load a descriptor when idle, step one character per free output slot.
   always_comb begin
      cur_in   = cur_ff;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      sub_in   = sub_ff;
      if (q_pop) begin
         cur_in  = q_desc;
         busy_in = 1'b1;
         sub_in  = 3'd0;
         if (q_desc.newline) begin
            phase_in = PH_NL;
         end else if (q_desc.escape) begin
            phase_in = PH_PFX;
         end else begin
            phase_in = PH_SP1;
         end
      end else if (emit) begin
         case (phase_ff)
            PH_NL: begin
               sub_in   = 3'd0;
               phase_in = cur_ff.escape ? PH_PFX : PH_SP1;
            end
            PH_PFX: begin
               if (sub_ff == 3'd6) begin
                  phase_in = PH_RED;
                  sub_in   = {1'b0, cur_ff.dig_red.start};
               end else begin
                  sub_in = sub_ff + 3'd1;
               end
            end
            PH_RED: begin
               if (sub_ff == 3'd0) phase_in = PH_SEP1;
               else sub_in = sub_ff - 3'd1;
            end
            PH_SEP1: begin
               phase_in = PH_GRN;
               sub_in   = {1'b0, cur_ff.dig_green.start};
            end
            PH_GRN: begin
               if (sub_ff == 3'd0) phase_in = PH_SEP2;
               else sub_in = sub_ff - 3'd1;
            end
            PH_SEP2: begin
               phase_in = PH_BLU;
               sub_in   = {1'b0, cur_ff.dig_blue.start};
            end
            PH_BLU: begin
               if (sub_ff == 3'd0) phase_in = PH_M;
               else sub_in = sub_ff - 3'd1;
            end
            PH_M:   phase_in = PH_SP1;
            PH_SP1: phase_in = PH_SP2;
            PH_SP2: begin
               sub_in = 3'd0;
               if (cur_ff.last) phase_in = PH_TAIL;
               else busy_in = 1'b0;
            end
            PH_TAIL: begin
               if (sub_ff == 3'd4) busy_in = 1'b0;
               else sub_in = sub_ff + 3'd1;
            end
            default: busy_in = 1'b0;
         endcase
      end
   end

   // Output register: holds one beat until it is taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (emit) begin
         out_valid_in         = 1'b1;
         out_data_in.text_byte = char;
         out_data_in.run_last  = final_char;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_NL;
         sub_ff       <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      out_data_ff <= out_data_in;
   end

endmodule

FILE: sv/ansi_truecolor_frame_encoder_unit.sv
// Top level of the truecolor escape encoder: register port, front end, queue and back end.
// Depends on atfe_pkg, atfe_front, atfe_queue and atfe_back.
//
//   channel   ports                        direction  beat
//   req       req_push/req_full/req_data   in         one pixel
//   rsp       rsp_pop/rsp_empty/rsp_data   out        one text character
//   csr       psel/penable/pwrite/...      in/out     row_length at byte 0
//
// Each pixel yields 2 to 27 characters, one per cycle while the receiver takes them, set by
// the back-end sequencer that owns the output register; it pauses to load each pixel.
// The front end takes a pixel whenever the two-entry queue has room.
// Reset is synchronous and active high; row_length returns to 192.
// A stall on rsp holds the back end; the front end keeps taking pixels until the queue fills.
`timescale 1ns / 1ps

module ansi_truecolor_frame_encoder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  atfe_pkg::req_type               req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output atfe_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [atfe_pkg::CsrAddrW-1:0]   csr_paddr,
   input  logic [atfe_pkg::CsrDataW-1:0]   csr_pwdata,
   output logic [atfe_pkg::CsrDataW-1:0]   csr_prdata,
   output logic                            csr_pready
);

   logic [atfe_pkg::RowLenW-1:0] row_length_ff, row_length_in;
   logic                         q_full;
   logic                         q_push;
   atfe_pkg::desc_type           q_push_desc;
   logic                         q_pop;
   atfe_pkg::desc_type           q_pop_desc;
   logic                         q_empty;
   logic                         csr_write;

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == atfe_pkg::RegRowLength) ?
                       {{(atfe_pkg::CsrDataW - atfe_pkg::RowLenW){1'b0}}, row_length_ff} : '0;

   always_comb begin
      row_length_in = row_length_ff;
      if (csr_write && (csr_paddr == atfe_pkg::RegRowLength)) begin
         row_length_in = csr_pwdata[atfe_pkg::RowLenW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= atfe_pkg::RowLenReset;
      end else begin
         row_length_ff <= row_length_in;
      end
   end

   assign req_full = q_full;

   atfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_data   (req_data),
      .row_length (row_length_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_desc     (q_push_desc)
   );

   atfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_desc  (q_pop_desc),
      .empty     (q_empty)
   );

   atfe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_desc    (q_pop_desc),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // The last beat of a pixel is either a trailing space or the closing newline.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.run_last) |->
      (rsp_data.text_byte == atfe_pkg::CharSpace || rsp_data.text_byte == atfe_pkg::CharNl))
      else $error("run_last on a character that cannot end a pixel");

   // Only printable text, escape and newline are ever produced.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |->
      ((rsp_data.text_byte >= 8'd32 && rsp_data.text_byte <= 8'd126) ||
       rsp_data.text_byte == atfe_pkg::CharEsc || rsp_data.text_byte == atfe_pkg::CharNl))
      else $error("unexpected character on the result channel");

   // Nothing is waiting right after reset.
   assert property (@(posedge clock) $past(reset) |-> (rsp_empty && !req_full))
      else $error("queues not empty after reset");
`endif

endmodule

FILE: dv/ansi_truecolor_frame_encoder_unit_test.sv
// Self-checking testbench for the truecolor escape encoder: directed pixels, then random frames.
// Depends on atfe_pkg and ansi_truecolor_frame_encoder_unit; reads no files.
`timescale 1ns / 1ps

module ansi_truecolor_frame_encoder_unit_test;

   localparam int CycleLimit = 400000;
   localparam int SettlePause = 4;

   typedef enum logic {STEP_PIXEL, STEP_ROW_LENGTH} step_kind_type;

   typedef struct {
      step_kind_type       kind;
      atfe_pkg::req_type   px;
      logic [31:0]         value;
      string               text;
   } plan_row_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_push = 1'b0;
   logic                                req_full;
   atfe_pkg::req_type                   req_data = '0;
   logic                                rsp_empty;
   logic                                rsp_pop = 1'b0;
   atfe_pkg::rsp_type                   rsp_data;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [atfe_pkg::CsrAddrW-1:0]       csr_paddr = '0;
   logic [atfe_pkg::CsrDataW-1:0]       csr_pwdata = '0;
   logic [atfe_pkg::CsrDataW-1:0]       csr_prdata;
   logic                                csr_pready;

   // Encoder state as the testbench tracks it.
   logic [atfe_pkg::RowLenW-1:0]        row_len_model = atfe_pkg::RowLenReset;
   logic [7:0]                          last_red, last_green, last_blue;
   logic                                color_sent;
   logic [atfe_pkg::RowLenW-1:0]        column;

   logic [7:0]                          pixel_text[$];
   atfe_pkg::rsp_type                   expected_chars[$];
   string                               typed_q[$];
   plan_row_type                        plan[$];
   atfe_pkg::req_type                   last_offer = '0;

   int                    mismatches = 0;
   int                    chars_seen = 0;
   int                    pixels_seen = 0;
   int                    frames_seen = 0;
   int                    settings_seen = 0;
   int                    cycle_count = 0;
   int                    gap_odds = 15;
   int                    rsp_odds = 15;
   int                    rsp_stall = 0;
   logic                  calm = 1'b0;
   logic                  hold_request = 1'b0;

   ansi_truecolor_frame_encoder_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Run limit; a hang ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("%0t: run limit of %0d cycles reached", $time, CycleLimit);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Unpadded decimal form of one channel.
   function automatic void add_decimal(input logic [7:0] v);
      if (v >= 8'd100) pixel_text.push_back(atfe_pkg::CharZero + v / 8'd100);
      if (v >= 8'd10) pixel_text.push_back(atfe_pkg::CharZero + (v / 8'd10) % 8'd10);
      pixel_text.push_back(atfe_pkg::CharZero + v % 8'd10);
   endfunction

   // Text that one pixel produces; also advances the tracked color and column state.
   function automatic void encode_pixel(input atfe_pkg::req_type px);
      pixel_text.delete();
      if (column == '0) pixel_text.push_back(atfe_pkg::CharNl);
      if (!color_sent || px.red != last_red || px.green != last_green || px.blue != last_blue)
      begin
         last_red   = px.red;
         last_green = px.green;
         last_blue  = px.blue;
         color_sent = 1'b1;
         pixel_text.push_back(atfe_pkg::CharEsc);
         pixel_text.push_back(atfe_pkg::CharBrack);
         pixel_text.push_back(atfe_pkg::CharFour);
         pixel_text.push_back(atfe_pkg::CharEight);
         pixel_text.push_back(atfe_pkg::CharSemi);
         pixel_text.push_back(atfe_pkg::CharTwo);
         pixel_text.push_back(atfe_pkg::CharSemi);
         add_decimal(px.red);
         pixel_text.push_back(atfe_pkg::CharSemi);
         add_decimal(px.green);
         pixel_text.push_back(atfe_pkg::CharSemi);
         add_decimal(px.blue);
         pixel_text.push_back(atfe_pkg::CharM);
      end
      pixel_text.push_back(atfe_pkg::CharSpace);
      pixel_text.push_back(atfe_pkg::CharSpace);
      if (32'(column) + 1 >= 32'(row_len_model)) column = '0;
      else column = column + 1'b1;
      if (px.frame_end) begin
         pixel_text.push_back(atfe_pkg::CharEsc);
         pixel_text.push_back(atfe_pkg::CharBrack);
         pixel_text.push_back(atfe_pkg::CharZero);
         pixel_text.push_back(atfe_pkg::CharM);
         pixel_text.push_back(atfe_pkg::CharNl);
         last_red   = '0;
         last_green = '0;
         last_blue  = '0;
         color_sent = 1'b0;
         column     = '0;
      end
   endfunction

   // Each accepted pixel queues its characters; a typed-in text takes the place of the
   // predicted one for the directed rows that carry it.
   always @(posedge clock) begin : take_pixel
      string text;
      if (reset) begin
         last_red   = '0;
         last_green = '0;
         last_blue  = '0;
         color_sent = 1'b0;
         column     = '0;
      end else if (req_push && !req_full) begin
         text = typed_q.pop_front();
         encode_pixel(req_data);
         if (text.len() != 0) begin
            pixel_text.delete();
            for (int i = 0; i < text.len(); i++) pixel_text.push_back(text[i]);
         end
         foreach (pixel_text[i])
            expected_chars.push_back('{text_byte: pixel_text[i],
                                       run_last: (i == pixel_text.size() - 1)});
         if (req_data.frame_end) frames_seen++;
      end
   end

   // Compare every accepted character beat with the oldest pending one.
   always @(posedge clock) begin : check_text
      atfe_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         chars_seen++;
         if (rsp_data.run_last) pixels_seen++;
         if (expected_chars.size() == 0) begin
            mismatches++;
            $display("%0t: character expected none actual %h",
                     $time, rsp_data.text_byte);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_data.text_byte !== want.text_byte) begin
               mismatches++;
               $display("%0t: text_byte expected %h actual %h",
                        $time, want.text_byte, rsp_data.text_byte);
            end
            if (rsp_data.run_last !== want.run_last) begin
               mismatches++;
               $display("%0t: run_last expected %b actual %b",
                        $time, want.run_last, rsp_data.run_last);
            end
         end
      end
   end

   // Receiver: random stall bursts, and one long hold-off when asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall = 300;
         end else if (rsp_stall == 0 && !calm && $urandom_range(0, 99) < rsp_odds) begin
            rsp_stall = $urandom_range(1, 9);
         end
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Offer one pixel beat, after an optional gap, and return at the edge that takes it.
   task automatic send_pixel(input atfe_pkg::req_type px, input string text);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < gap_odds) gap = $urandom_range(1, 9);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_q.push_back(text);
      req_data <= px;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
   endtask

   // Stop offering and wait until every pending character has come out.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (typed_q.size() != 0 || expected_chars.size() != 0) @(posedge clock);
      repeat (SettlePause) @(posedge clock);
   endtask

   // Write row_length over the register port, then read it back.
   task automatic write_row_length(input logic [31:0] value);
      logic [31:0] readback;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= atfe_pkg::RegRowLength;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      row_len_model = value[atfe_pkg::RowLenW-1:0];
      settings_seen++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== {{(atfe_pkg::CsrDataW - atfe_pkg::RowLenW){1'b0}},
                        value[atfe_pkg::RowLenW-1:0]}) begin
         mismatches++;
         $display("%0t: row_length read expected %h actual %h",
                  $time, value[atfe_pkg::RowLenW-1:0], readback);
      end
   endtask

   function automatic void add_pixel(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic fe, input string text);
      plan_row_type row;
      row.kind = STEP_PIXEL;
      row.px.red = r;
      row.px.green = g;
      row.px.blue = b;
      row.px.frame_end = fe;
      row.value = '0;
      row.text = text;
      plan.push_back(row);
   endfunction

   function automatic void add_length(input logic [31:0] v);
      plan_row_type row;
      row.kind = STEP_ROW_LENGTH;
      row.px = '0;
      row.value = v;
      row.text = "";
      plan.push_back(row);
   endfunction

   // Channel values at the digit-count boundaries and the extremes.
   function automatic logic [7:0] boundary_value();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd9;
         2: return 8'd10;
         3: return 8'd99;
         4: return 8'd100;
         5: return 8'd199;
         6: return 8'd200;
         default: return 8'd255;
      endcase
   endfunction

   // Random pixel: repeats of the last color keep runs without escapes in the mix.
   function automatic atfe_pkg::req_type random_pixel();
      atfe_pkg::req_type px;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
         px = last_offer;
      end else if (pick < 6) begin
         px.red = boundary_value();
         px.green = boundary_value();
         px.blue = boundary_value();
      end else begin
         px.red = 8'($urandom());
         px.green = 8'($urandom());
         px.blue = 8'($urandom());
      end
      px.frame_end = ($urandom_range(0, 11) == 0);
      last_offer = px;
      return px;
   endfunction

   initial begin
      logic [31:0] length_pick;

      // Directed rows; texts are typed in where they follow from the state at a glance.
      add_pixel(8'd0, 8'd0, 8'd0, 1'b0, "\n\033[48;2;0;0;0m  ");
      add_pixel(8'd0, 8'd0, 8'd0, 1'b0, "  ");
      add_pixel(8'd255, 8'd255, 8'd255, 1'b0, "\033[48;2;255;255;255m  ");
      add_pixel(8'd9, 8'd10, 8'd99, 1'b0, "\033[48;2;9;10;99m  ");
      add_pixel(8'd100, 8'd200, 8'd5, 1'b1, "\033[48;2;100;200;5m  \033[0m\n");
      // After a frame end the color is unknown again, even for black.
      add_pixel(8'd0, 8'd0, 8'd0, 1'b0, "\n\033[48;2;0;0;0m  ");
      add_pixel(8'd0, 8'd0, 8'd0, 1'b1, "  \033[0m\n");
      add_pixel(8'd255, 8'd255, 8'd255, 1'b1, "\n\033[48;2;255;255;255m  \033[0m\n");
      add_length(32'd1);
      add_pixel(8'd1, 8'd2, 8'd3, 1'b0, "\n\033[48;2;1;2;3m  ");
      add_pixel(8'd1, 8'd2, 8'd3, 1'b0, "\n  ");
      // A zero row length puts a newline before every pixel.
      add_length(32'd0);
      add_pixel(8'd1, 8'd2, 8'd3, 1'b0, "\n  ");
      add_pixel(8'd170, 8'd85, 8'd254, 1'b0, "");
      add_length(32'hFFFF_FFFF);
      add_pixel(8'd85, 8'd170, 8'd1, 1'b0, "");
      add_pixel(8'd85, 8'd170, 8'd1, 1'b0, "");
      add_pixel(8'd254, 8'd1, 8'd128, 1'b0, "");
      add_pixel(8'd0, 8'd255, 8'd0, 1'b0, "");
      add_pixel(8'd128, 8'd128, 8'd128, 1'b0, "");
      // Row length cut below the current column in the middle of a row.
      add_length(32'd3);
      add_pixel(8'd7, 8'd7, 8'd7, 1'b0, "");
      add_pixel(8'd7, 8'd7, 8'd7, 1'b1, "");

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == STEP_PIXEL) begin
            send_pixel(plan[i].px, plan[i].text);
         end else begin
            drain();
            write_row_length(plan[i].value);
         end
      end

      // Random phases, each under its own row length and stall mix.
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph)
            0: length_pick = 32'd0;
            1: length_pick = 32'd1;
            2: length_pick = 32'd4095;
            3: length_pick = $urandom_range(2, 8);
            4: length_pick = $urandom_range(1, 4095);
            5: length_pick = 32'd3;
            6: length_pick = $urandom_range(2, 16);
            default: length_pick = $urandom_range(1, 12);
         endcase
         // Upper data bits are noise the register must drop.
         length_pick[31:atfe_pkg::RowLenW] = 20'($urandom());
         write_row_length(length_pick);
         gap_odds = (ph == 2 || ph == 5) ? 0 : $urandom_range(5, 30);
         rsp_odds = (ph == 5) ? 0 : $urandom_range(5, 30);
         calm = (ph == 7);
         // Long receiver hold-off while pixels keep coming, so the input backs up.
         if (ph == 2) hold_request = 1'b1;
         for (int k = 0; k < 50; k++) send_pixel(random_pixel(), "");
      end

      drain();
      repeat (30) @(posedge clock);

      $display("Checked %0d characters from %0d pixels in %0d frames.",
               chars_seen, pixels_seen, frames_seen);
      $display("Row length took %0d settings, including 0, 1 and 4095, under both stalls.",
               settings_seen);
      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/atfe_pkg.sv
sv/atfe_front.sv
sv/atfe_queue.sv
sv/atfe_back.sv
sv/ansi_truecolor_frame_encoder_unit.sv
dv/ansi_truecolor_frame_encoder_unit_test.sv
